/* hw/rtl/mco_pkg.sv */
`timescale 1ns / 1ps

package mco_pkg;

	localparam int DEF_MAX_MATRICES = 16;
	localparam int DEF_DIM_WIDTH    = 16;

	localparam int IN_W    = 16;
	localparam int COST_W  = 64;
	localparam int SPLIT_W = 4;
	localparam int OUT_W   = 72;

	localparam logic [COST_W-1:0] COST_MAX = '1;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_OVERFULL = 2'd1,
		ST_SHORT    = 2'd2
	} status_t;

	typedef struct packed {
		logic valid;
		logic first;
		logic last_k;
	} tag_t;

	typedef struct packed {
		logic done;
		logic sat;
	} eval_stat_t;

	function automatic logic [COST_W:0] sat_add(logic [COST_W-1:0] a, logic [COST_W-1:0] b);
		logic [COST_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s[COST_W] || s[COST_W-1:0] == COST_MAX) begin
			return {1'b1, COST_MAX};
		end
		return {1'b0, s[COST_W-1:0]};
	endfunction

endpackage

/* hw/rtl/mco_eval.sv */
`timescale 1ns / 1ps

module mco_eval #(
	parameter int MAX_MATRICES = mco_pkg::DEF_MAX_MATRICES,
	parameter int DIM_WIDTH    = mco_pkg::DEF_DIM_WIDTH,
	localparam int MI_W        = (MAX_MATRICES > 1) ? $clog2(MAX_MATRICES) : 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mco_pkg::tag_t                 tag,
	input  logic [MI_W-1:0]               k,
	input  logic [mco_pkg::COST_W-1:0]    left,
	input  logic [mco_pkg::COST_W-1:0]    right,
	input  logic [DIM_WIDTH-1:0]          dk,
	input  logic [DIM_WIDTH-1:0]          di,
	input  logic [DIM_WIDTH-1:0]          dj,
	output mco_pkg::eval_stat_t           stat,
	output logic [mco_pkg::COST_W-1:0]    best_cost,
	output logic [MI_W-1:0]               best_k
);

	localparam int P1_W = 2 * DIM_WIDTH;
	localparam int P2_W = 3 * DIM_WIDTH;

	mco_pkg::tag_t                 tag_s1, tag_s2, tag_s3;
	logic [MI_W-1:0]               k_s1, k_s2, k_s3;
	logic [mco_pkg::COST_W-1:0]    sum_s2, sum_s3;
	logic [P1_W-1:0]               prod_s2;
	logic [mco_pkg::COST_W-1:0]    prod_s3;
	logic [mco_pkg::COST_W-1:0]    best_q;
	logic [MI_W-1:0]               best_k_q;

	logic [mco_pkg::COST_W-1:0]    left_v, right_v;
	logic [mco_pkg::COST_W:0]      sum1, sum3;
	logic [P1_W-1:0]               prod1;
	logic [P2_W-1:0]               prod2;
	logic                          take;

	always_comb begin
		left_v  = tag_s1.first ? '0 : left;
		right_v = tag_s1.last_k ? '0 : right;
		sum1    = mco_pkg::sat_add(left_v, right_v);
		prod1   = P1_W'(di) * P1_W'(dk);
		prod2   = P2_W'(prod_s2) * P2_W'(dj);
		sum3    = mco_pkg::sat_add(sum_s3, prod_s3);
		take    = tag_s3.first || (sum3[mco_pkg::COST_W-1:0] < best_q);
	end

	assign best_cost = take ? sum3[mco_pkg::COST_W-1:0] : best_q;
	assign best_k    = take ? k_s3 : best_k_q;
	assign stat.done = tag_s3.valid && tag_s3.last_k;
	assign stat.sat  = (tag_s1.valid && sum1[mco_pkg::COST_W])
	                || (tag_s3.valid && sum3[mco_pkg::COST_W]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
			tag_s3 <= '0;
		end else begin
			tag_s1 <= tag;
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
		end
	end

	always_ff @(posedge clk) begin
		k_s1    <= k;
		k_s2    <= k_s1;
		k_s3    <= k_s2;
		sum_s2  <= sum1[mco_pkg::COST_W-1:0];
		prod_s2 <= prod1;
		sum_s3  <= sum_s2;
		prod_s3 <= mco_pkg::COST_W'(prod2);
		if (tag_s3.valid) begin
			best_q   <= best_cost;
			best_k_q <= best_k;
		end
	end

endmodule

/* hw/rtl/matrix_chain_order_dp.sv */
`timescale 1ns / 1ps

// Matrix chain order solver.
// Input stream: one dimension per transaction in s_tdata; s_tlast marks the final
// dimension of a chain and starts the solve. A chain of m dimensions is m-1 matrices.
// Output stream: one transaction per chain carrying the minimum multiplication
// count, the outermost split, a saturation flag and a status code.
// Loading accepts a dimension on every handshake. After the last dimension the
// solver evaluates every split point through a three-stage read/add/multiply
// pipeline on the cost memory, one split per cycle, and drains it before the next
// interval; n matrices give S = (n^3-n)/6 splits in I = n(n-1)/2 intervals.
// Overfull, too-short and single-matrix chains skip the solve and go straight to
// the result.
// s_tready is low while solving. A finished result sits in the output register;
// if the receiver stalls, the block holds in its final state until the register
// frees up. Reset empties the chain, clears the output register and readies the
// input. The memories are not cleared; every entry that is used is written before it is read.
module matrix_chain_order_dp #(
	parameter int MAX_MATRICES = mco_pkg::DEF_MAX_MATRICES,
	parameter int DIM_WIDTH    = mco_pkg::DEF_DIM_WIDTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [mco_pkg::IN_W-1:0]   s_tdata,   // dimension[15:0]
	input  logic                       s_tlast,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [mco_pkg::OUT_W-1:0]  m_tdata    // min_cost[63:0], top_split[67:64],
	                                              // saturated[68], status[70:69]
);

	localparam int MI_W   = (MAX_MATRICES > 1) ? $clog2(MAX_MATRICES) : 1;
	localparam int DI_W   = $clog2(MAX_MATRICES + 1);
	localparam int CNT_W  = $clog2(MAX_MATRICES + 2);
	localparam int N_DIMS = MAX_MATRICES + 1;
	localparam int AW     = $clog2(MAX_MATRICES * MAX_MATRICES);
	localparam int DEPTH  = MAX_MATRICES * MAX_MATRICES;
	localparam logic [AW-1:0] ROW = AW'(MAX_MATRICES);

	typedef enum logic [2:0] {
		S_LOAD,
		S_SET_I,
		S_SET_J,
		S_ISSUE,
		S_DRAIN,
		S_FIN
	} state_t;

	state_t                          state_q;
	logic [CNT_W-1:0]                count_q;
	logic                            overfull_q;
	logic                            ovf_q;
	logic [DI_W-1:0]                 nmat_q;
	logic [DI_W-1:0]                 len_q;
	logic [MI_W-1:0]                 i_q, j_q, k_q;
	logic [DIM_WIDTH-1:0]            di_q, dj_q;
	logic [mco_pkg::COST_W-1:0]      res_cost_q;
	logic [mco_pkg::SPLIT_W-1:0]     res_split_q;
	logic                            res_sat_q;
	mco_pkg::status_t                res_status_q;
	logic                            out_valid_q;
	logic [mco_pkg::OUT_W-1:0]       out_data_q;

	logic [DIM_WIDTH-1:0]            dim_mem [N_DIMS];
	logic [DIM_WIDTH-1:0]            dim_rdata_q;
	logic [mco_pkg::COST_W-1:0]      cost_mem [DEPTH];
	logic [mco_pkg::COST_W-1:0]      left_q, right_q;

	logic [DIM_WIDTH-1:0]            dim_in;
	logic [DI_W-1:0]                 dim_raddr;
	logic                            s_fire;
	logic                            dim_we;
	logic                            out_load;
	logic [MI_W-1:0]                 k_next;
	logic                            last_k;
	mco_pkg::tag_t                   tag;
	mco_pkg::eval_stat_t             stat;
	logic [mco_pkg::COST_W-1:0]      best_cost;
	logic [MI_W-1:0]                 best_k;
	logic [mco_pkg::SPLIT_W-1:0]     best_split;
	logic [AW-1:0]                   addr_l, addr_r, addr_w;
	logic                            cost_we;
	logic                            ivl_end;
	logic                            solve_end;

	if (DIM_WIDTH <= mco_pkg::IN_W) begin : g_dim_narrow
		assign dim_in = s_tdata[DIM_WIDTH-1:0];
	end else begin : g_dim_wide
		assign dim_in = {{(DIM_WIDTH - mco_pkg::IN_W){1'b0}}, s_tdata};
	end

	if (MI_W >= mco_pkg::SPLIT_W) begin : g_split_trunc
		assign best_split = best_k[mco_pkg::SPLIT_W-1:0];
	end else begin : g_split_ext
		assign best_split = {{(mco_pkg::SPLIT_W - MI_W){1'b0}}, best_k};
	end

	assign s_tready = (state_q == S_LOAD);
	assign s_fire   = s_tvalid && s_tready;
	assign dim_we   = s_fire && (count_q < CNT_W'(N_DIMS));
	assign out_load = (state_q == S_FIN) && (!out_valid_q || m_tready);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	assign k_next    = k_q + MI_W'(1);
	assign last_k    = (k_next == j_q);
	assign tag.valid = (state_q == S_ISSUE);
	assign tag.first = (k_q == i_q);
	assign tag.last_k = last_k;

	assign addr_l  = AW'(i_q) * ROW + AW'(k_q);
	assign addr_r  = AW'(k_next) * ROW + AW'(j_q);
	assign addr_w  = AW'(i_q) * ROW + AW'(j_q);
	assign cost_we = (state_q == S_DRAIN) && stat.done;

	assign ivl_end   = (j_q == MI_W'(nmat_q - DI_W'(1)));
	assign solve_end = ivl_end && (len_q == nmat_q);

	always_comb begin
		unique case (state_q)
			S_SET_I: dim_raddr = DI_W'(i_q);
			S_SET_J: dim_raddr = DI_W'(j_q) + DI_W'(1);
			default: dim_raddr = DI_W'(k_q) + DI_W'(1);
		endcase
	end

	always_ff @(posedge clk) begin
		if (dim_we) begin
			dim_mem[count_q[DI_W-1:0]] <= dim_in;
		end
		dim_rdata_q <= dim_mem[dim_raddr];
	end

	always_ff @(posedge clk) begin
		if (cost_we) begin
			cost_mem[addr_w] <= best_cost;
		end
		left_q  <= cost_mem[addr_l];
		right_q <= cost_mem[addr_r];
	end

	mco_eval #(
		.MAX_MATRICES (MAX_MATRICES),
		.DIM_WIDTH    (DIM_WIDTH)
	) u_eval (
		.clk       (clk),
		.arst_n    (arst_n),
		.tag       (tag),
		.k         (k_q),
		.left      (left_q),
		.right     (right_q),
		.dk        (dim_rdata_q),
		.di        (di_q),
		.dj        (dj_q),
		.stat      (stat),
		.best_cost (best_cost),
		.best_k    (best_k)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_LOAD;
			count_q      <= '0;
			overfull_q   <= 1'b0;
			ovf_q        <= 1'b0;
			nmat_q       <= '0;
			len_q        <= '0;
			i_q          <= '0;
			j_q          <= '0;
			k_q          <= '0;
			di_q         <= '0;
			dj_q         <= '0;
			res_cost_q   <= '0;
			res_split_q  <= '0;
			res_sat_q    <= 1'b0;
			res_status_q <= mco_pkg::ST_OK;
			out_valid_q  <= 1'b0;
			out_data_q   <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (s_fire && s_tlast) begin
				ovf_q <= 1'b0;
			end else begin
				ovf_q <= ovf_q | stat.sat;
			end
			unique case (state_q)
				S_LOAD: begin
					if (s_fire) begin
						if (s_tlast) begin
							count_q     <= '0;
							overfull_q  <= 1'b0;
							res_cost_q  <= '0;
							res_split_q <= '0;
							res_sat_q   <= 1'b0;
							nmat_q      <= DI_W'(count_q);
							len_q       <= DI_W'(2);
							i_q         <= '0;
							j_q         <= MI_W'(1);
							k_q         <= '0;
							priority if (overfull_q || !dim_we) begin
								res_status_q <= mco_pkg::ST_OVERFULL;
								state_q      <= S_FIN;
							end else if (count_q == '0) begin
								res_status_q <= mco_pkg::ST_SHORT;
								state_q      <= S_FIN;
							end else if (count_q == CNT_W'(1)) begin
								res_status_q <= mco_pkg::ST_OK;
								state_q      <= S_FIN;
							end else begin
								res_status_q <= mco_pkg::ST_OK;
								state_q      <= S_SET_I;
							end
						end else if (dim_we) begin
							count_q <= count_q + CNT_W'(1);
						end else begin
							overfull_q <= 1'b1;
						end
					end
				end
				S_SET_I: begin
					state_q <= S_SET_J;
				end
				S_SET_J: begin
					di_q    <= dim_rdata_q;
					state_q <= S_ISSUE;
				end
				S_ISSUE: begin
					if (k_q == i_q) begin
						dj_q <= dim_rdata_q;
					end
					if (last_k) begin
						state_q <= S_DRAIN;
					end else begin
						k_q <= k_next;
					end
				end
				S_DRAIN: begin
					if (stat.done) begin
						priority if (solve_end) begin
							res_cost_q  <= best_cost;
							res_split_q <= best_split;
							res_sat_q   <= ovf_q | stat.sat;
							state_q     <= S_FIN;
						end else if (ivl_end) begin
							len_q   <= len_q + DI_W'(1);
							i_q     <= '0;
							j_q     <= MI_W'(len_q);
							k_q     <= '0;
							state_q <= S_SET_I;
						end else begin
							i_q     <= i_q + MI_W'(1);
							j_q     <= j_q + MI_W'(1);
							k_q     <= i_q + MI_W'(1);
							state_q <= S_SET_I;
						end
					end
				end
				S_FIN: begin
					if (out_load) begin
						out_data_q <= {1'b0, res_status_q, res_sat_q, res_split_q, res_cost_q};
						state_q    <= S_LOAD;
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

endmodule

/* hw/rtl/mco_checker.sv */
`timescale 1ns / 1ps

module mco_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       s_tvalid,
	input logic                       s_tready,
	input logic                       s_tlast,
	input logic                       m_tvalid,
	input logic                       m_tready,
	input logic [mco_pkg::OUT_W-1:0]  m_tdata
);

	logic [1:0] status;
	logic       not_ok;

	assign status = m_tdata[70:69];
	assign not_ok = (status != 2'(mco_pkg::ST_OK));

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	a_last_closes: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tlast |=> !s_tready)
		else $error("input taken right after chain end");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (status == 2'(mco_pkg::ST_OK) || status == 2'(mco_pkg::ST_OVERFULL)
		              || status == 2'(mco_pkg::ST_SHORT)))
		else $error("status code out of range");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && not_ok |-> (m_tdata[68:0] == '0))
		else $error("error result carries data");

endmodule

bind matrix_chain_order_dp mco_checker u_mco_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tlast  (s_tlast),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
